>>> rtl/rfre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfre_pkg
// Shared types and constants of the Raft follower engine: item layouts,
// action, role and status codes, register indexes and timer widths.
// ----------------------------------------------------------------------------
package rfre_pkg;

    localparam int IDX_W       = 31;
    localparam int TERM_W      = 31;
    localparam int ID_BITS     = 8;
    localparam int TMR_W       = 16;
    localparam int CFG_W       = 15;
    localparam int LOG_DEPTH_DEF = 256;

    localparam logic [TMR_W-1:0]  LFSR_SEED = 16'hACE1;
    localparam logic [TMR_W-1:0]  TMR_MAX   = '1;
    localparam logic [IDX_W-1:0]  IDX_MAX   = '1;
    localparam logic [ID_BITS:0]  NO_ID     = '1;

    localparam logic [CFG_W-1:0]  ELECTION_RST  = 15'd10;
    localparam logic [CFG_W-1:0]  HEARTBEAT_RST = 15'd2;
    localparam logic [7:0]        COMPACT_RST   = 8'd4;

    // action codes
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_VOTE  = 3'd1;
    localparam logic [2:0] ACT_PRE   = 3'd2;
    localparam logic [2:0] ACT_APP   = 3'd3;
    localparam logic [2:0] ACT_SNAP  = 3'd4;

    // role codes
    localparam logic [1:0] ROLE_CAND   = 2'd1;
    localparam logic [1:0] ROLE_LEADER = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_STALE    = 3'd1;
    localparam logic [2:0] ST_COMPACT  = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // register indexes
    localparam logic [1:0] CFG_ELECTION  = 2'd0;
    localparam logic [1:0] CFG_HEARTBEAT = 2'd1;
    localparam logic [1:0] CFG_COMPACT   = 2'd2;

    typedef struct packed {
        logic [2:0]         action;
        logic [1:0]         local_role;
        logic [TERM_W-1:0]  msg_term;
        logic [ID_BITS-1:0] sender_id;
        logic [IDX_W-1:0]   ref_index;
        logic [TERM_W-1:0]  ref_term;
        logic [IDX_W-1:0]   leader_commit_index;
        logic               has_entry;
        logic [7:0]         entry_pos;
        logic [TERM_W-1:0]  entry_term;
        logic               entry_last;
    } t_in;

    typedef struct packed {
        logic [TERM_W-1:0]  reply_term;
        logic               success;
        logic [IDX_W-1:0]   match_point;
        logic [IDX_W-1:0]   retry_index;
        logic signed [31:0] retry_term;
        logic [2:0]         status;
        logic [IDX_W-1:0]   commit_point;
        logic               election_due;
        logic               heartbeat_due;
        logic               became_follower;
    } t_out;

    // divider handshake
    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_div_rsp;

endpackage
`default_nettype wire

>>> rtl/raft_follower_rpc_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raft_follower_rpc_engine
// Raft voter and follower with pre-vote, a ring of entry terms and timers.
// ----------------------------------------------------------------------------
// One item is handled at a time: the block drops ready after taking an item
// and raises it again once the result item sits in the output register. A
// tick or a message that needs no log lookup passes from dispatch through the
// timer step to the output step. Each log lookup adds one read of the
// entry-term memory, registered; an append that passes its check adds steps
// for placing the entry and the commit, and a conflict walk-back adds a read
// and a check per entry examined. Whenever the election timer is restarted,
// the new timeout is drawn through a remainder unit before the result is
// issued. A stalled output register holds the finished item until it frees.
// LOG_DEPTH must be a power of two; the ring is indexed by the low bits of the
// log index. Ring entries hold no reset value: every entry that is read was
// stored first.
// ----------------------------------------------------------------------------
module raft_follower_rpc_engine #(
    parameter int LOG_DEPTH = rfre_pkg::LOG_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output      logic                       o_in_ready,
    input  wire rfre_pkg::t_in              i_in_item,
    output      logic                       o_out_valid,
    input  wire logic                       i_out_ready,
    output      rfre_pkg::t_out             o_out_item,
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [rfre_pkg::CFG_W-1:0] i_cfg_data
);
    import rfre_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam logic [31:0] DEPTH32 = 32'(LOG_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_RD, S_VOTE, S_PRE, S_APP_PREV, S_WALK, S_WALK_CHK,
        S_WALK_END, S_APP_ENT, S_APP_G, S_APP_PUT, S_COMMIT, S_COMP, S_SNAP,
        S_TIMER, S_DIV, S_OUT
    } t_state;

    t_state             r_state, r_ret;
    t_in                r_in;
    t_out               r_res, r_out;
    logic               r_ov;

    logic [CFG_W-1:0]   r_ebase, r_hbeat;
    logic [7:0]         r_thr;

    logic [TERM_W-1:0]  r_term;
    logic [ID_BITS:0]   r_vote, r_leader;
    logic [IDX_W-1:0]   r_base, r_last, r_commit;
    logic [TERM_W-1:0]  r_base_term;
    logic [TMR_W-1:0]   r_since_contact, r_timeout, r_since_beat, r_lfsr;
    logic               r_tpend;

    logic [IDX_W-1:0]   r_rd_idx, r_ci, r_new;
    logic [TERM_W-1:0]  r_ct, r_mem_q;
    logic [TERM_W-1:0]  mem [LOG_DEPTH];

    logic               div_start;
    t_div_rsp           div_rsp;

    // combinational helpers
    logic [TERM_W-1:0]  rd_term;
    logic [TMR_W-1:0]   lfsr_nx, sc_inc, sb_inc;
    logic [CFG_W-1:0]   eb;
    logic [31:0]        g, last_p1;
    logic [IDX_W-1:0]   last_inc, new_commit;
    logic               utd, put_write, recent, is_cand_lead, out_load;

    function automatic logic [IDX_W-1:0] inc31(input logic [IDX_W-1:0] v);
        return (v == IDX_MAX) ? v : v + 1'b1;
    endfunction

    always_comb begin
        rd_term  = (r_rd_idx == r_base) ? r_base_term : r_mem_q;
        lfsr_nx  = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[TMR_W-1:1]};
        sc_inc   = (r_since_contact == TMR_MAX) ? r_since_contact : r_since_contact + 1'b1;
        sb_inc   = (r_since_beat == TMR_MAX) ? r_since_beat : r_since_beat + 1'b1;
        eb       = (r_ebase == '0) ? CFG_W'(1) : r_ebase;
        g        = {1'b0, r_in.ref_index} + 32'd1 + {24'd0, r_in.entry_pos};
        last_p1  = {1'b0, r_last} + 32'd1;
        last_inc = inc31(r_last);
        utd      = (r_in.ref_term != rd_term) ? (r_in.ref_term > rd_term)
                                              : (r_in.ref_index >= r_last);
        put_write = (g == last_p1) && ((g - {1'b0, r_base}) <= DEPTH32);
        new_commit = (r_in.leader_commit_index < r_new) ? r_in.leader_commit_index
                                                        : r_new;
        recent   = (r_in.local_role == ROLE_LEADER) ||
                   ((r_leader != NO_ID) &&
                    ({1'b0, r_since_contact} < {1'b0, r_hbeat, 1'b0}));
        is_cand_lead = (r_in.local_role == ROLE_CAND) ||
                       (r_in.local_role == ROLE_LEADER);
        div_start = (r_state == S_TIMER) && r_tpend;
        out_load  = (r_state == S_OUT) && (!r_ov || i_out_ready);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    rfre_mod16 u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_lfsr),
        .i_divisor  (eb),
        .o_rsp      (div_rsp)
    );

    // entry-term ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[r_rd_idx[AW-1:0]];
        if (r_state == S_APP_PUT && put_write)
            mem[g[AW-1:0]] <= r_in.entry_term;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ebase <= ELECTION_RST;
            r_hbeat <= HEARTBEAT_RST;
            r_thr   <= COMPACT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ELECTION:  r_ebase <= i_cfg_data;
                CFG_HEARTBEAT: r_hbeat <= i_cfg_data;
                CFG_COMPACT:   r_thr   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_ret           <= S_IDLE;
            r_ov            <= 1'b0;
            r_term          <= '0;
            r_vote          <= NO_ID;
            r_leader        <= NO_ID;
            r_base          <= '0;
            r_base_term     <= '0;
            r_last          <= '0;
            r_commit        <= '0;
            r_since_contact <= '0;
            r_since_beat    <= '0;
            r_timeout       <= {1'b0, ELECTION_RST};
            r_lfsr          <= LFSR_SEED;
            r_tpend         <= 1'b0;
            r_rd_idx        <= '0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_item;
                        // start from a tick-style result
                        r_res   <= '{reply_term: '0, success: 1'b0, match_point: '0,
                                     retry_index: '0, retry_term: -32'sd1,
                                     status: ST_OK, commit_point: '0,
                                     election_due: 1'b0, heartbeat_due: 1'b0,
                                     became_follower: 1'b0};
                        r_tpend <= 1'b0;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    unique case (r_in.action)
                        ACT_TICK: begin
                            r_state <= S_TIMER;
                            if (r_in.local_role == ROLE_LEADER) begin
                                r_since_contact <= sc_inc;
                                if (sb_inc >= {1'b0, r_hbeat}) begin
                                    r_res.heartbeat_due <= 1'b1;
                                    r_since_beat <= '0;
                                end else begin
                                    r_since_beat <= sb_inc;
                                end
                            end else if (sc_inc >= r_timeout) begin
                                r_res.election_due <= 1'b1;
                                r_lfsr <= lfsr_nx;
                                r_since_contact <= '0;
                                r_tpend <= 1'b1;
                            end else begin
                                r_since_contact <= sc_inc;
                            end
                        end
                        ACT_VOTE: begin
                            if (r_in.msg_term < r_term) begin
                                r_res.status <= ST_STALE;
                                r_state <= S_TIMER;
                            end else begin
                                if (r_in.msg_term > r_term) begin
                                    r_term   <= r_in.msg_term;
                                    r_vote   <= NO_ID;
                                    r_leader <= NO_ID;
                                    r_since_beat <= '0;
                                    r_lfsr <= lfsr_nx;
                                    r_since_contact <= '0;
                                    r_tpend <= 1'b1;
                                    r_res.became_follower <= 1'b1;
                                end
                                r_rd_idx <= r_last;
                                r_ret    <= S_VOTE;
                                r_state  <= S_RD;
                            end
                        end
                        ACT_PRE: begin
                            if (r_in.msg_term <= r_term) begin
                                r_res.status <= ST_STALE;
                                r_state <= S_TIMER;
                            end else if (!recent) begin
                                r_rd_idx <= r_last;
                                r_ret    <= S_PRE;
                                r_state  <= S_RD;
                            end else begin
                                r_state <= S_TIMER;
                            end
                        end
                        ACT_APP, ACT_SNAP: begin
                            if (r_in.msg_term < r_term) begin
                                r_res.status <= ST_STALE;
                                r_state <= S_TIMER;
                                if (r_in.action == ACT_APP) begin
                                    r_res.match_point <= r_last;
                                    r_res.retry_index <= last_inc;
                                end else begin
                                    r_res.match_point <= r_base;
                                end
                            end else begin
                                // leader contact: adopt term or step down
                                if (r_in.msg_term > r_term) begin
                                    r_term <= r_in.msg_term;
                                    r_vote <= NO_ID;
                                end
                                if (r_in.msg_term > r_term || is_cand_lead) begin
                                    r_since_beat <= '0;
                                    r_res.became_follower <= 1'b1;
                                end
                                r_leader <= {1'b0, r_in.sender_id};
                                r_lfsr <= lfsr_nx;
                                r_since_contact <= '0;
                                r_tpend <= 1'b1;
                                if (r_in.action == ACT_SNAP) begin
                                    if (r_in.ref_index > r_base) begin
                                        r_rd_idx <= r_in.ref_index;
                                        r_ret    <= S_SNAP;
                                        r_state  <= S_RD;
                                    end else begin
                                        r_res.success     <= 1'b1;
                                        r_res.match_point <= r_base;
                                        r_state <= S_TIMER;
                                    end
                                end else if (r_in.ref_index < r_base) begin
                                    r_res.status <= ST_COMPACT;
                                    r_res.match_point <= (r_base != '0) ? r_base - 1'b1
                                                                        : '0;
                                    r_res.retry_index <= r_base;
                                    r_res.retry_term  <= {1'b0, r_base_term};
                                    r_state <= S_TIMER;
                                end else if (r_in.ref_index > r_last) begin
                                    r_res.status <= ST_MISSING;
                                    r_res.match_point <= r_last;
                                    r_res.retry_index <= last_inc;
                                    r_state <= S_TIMER;
                                end else begin
                                    r_rd_idx <= r_in.ref_index;
                                    r_ret    <= S_APP_PREV;
                                    r_state  <= S_RD;
                                end
                            end
                        end
                        default: r_state <= S_TIMER;
                    endcase
                end
                S_RD: r_state <= r_ret;
                S_VOTE: begin
                    if ((r_vote == NO_ID || r_vote == {1'b0, r_in.sender_id}) && utd) begin
                        r_vote <= {1'b0, r_in.sender_id};
                        r_lfsr <= lfsr_nx;
                        r_since_contact <= '0;
                        r_tpend <= 1'b1;
                        r_res.success <= 1'b1;
                    end
                    r_state <= S_TIMER;
                end
                S_PRE: begin
                    if (utd) r_res.success <= 1'b1;
                    r_state <= S_TIMER;
                end
                S_APP_PREV: begin
                    if (rd_term != r_in.ref_term) begin
                        r_ct    <= rd_term;
                        r_ci    <= r_in.ref_index;
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_APP_ENT;
                    end
                end
                S_WALK: begin
                    // step back while the previous entry has the same term
                    if (r_ci > r_base) begin
                        r_rd_idx <= r_ci - 1'b1;
                        r_ret    <= S_WALK_CHK;
                        r_state  <= S_RD;
                    end else begin
                        r_state <= S_WALK_END;
                    end
                end
                S_WALK_CHK: begin
                    if (rd_term == r_ct) begin
                        r_ci    <= r_ci - 1'b1;
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_WALK_END;
                    end
                end
                S_WALK_END: begin
                    r_res.status      <= ST_MISMATCH;
                    r_res.retry_term  <= {1'b0, r_ct};
                    r_res.retry_index <= r_ci;
                    r_res.match_point <= (r_ci != '0) ? r_ci - 1'b1 : '0;
                    r_state <= S_TIMER;
                end
                S_APP_ENT: begin
                    if (!r_in.has_entry) begin
                        r_new   <= r_in.ref_index;
                        r_state <= S_COMMIT;
                    end else begin
                        r_new <= g[IDX_W-1:0];
                        if (g[31]) begin
                            r_res.status      <= ST_FULL;
                            r_res.match_point <= r_last;
                            r_res.retry_index <= last_inc;
                            r_state <= S_TIMER;
                        end else if (g[IDX_W-1:0] <= r_last) begin
                            r_rd_idx <= g[IDX_W-1:0];
                            r_ret    <= S_APP_G;
                            r_state  <= S_RD;
                        end else begin
                            r_state <= S_APP_PUT;
                        end
                    end
                end
                S_APP_G: begin
                    // drop the conflicting suffix
                    if (rd_term != r_in.entry_term) r_last <= g[IDX_W-1:0] - 1'b1;
                    r_state <= S_APP_PUT;
                end
                S_APP_PUT: begin
                    if (g > last_p1) begin
                        r_res.status      <= ST_MISSING;
                        r_res.match_point <= r_last;
                        r_res.retry_index <= last_inc;
                        r_state <= S_TIMER;
                    end else if (g == last_p1 && !put_write) begin
                        r_res.status      <= ST_FULL;
                        r_res.match_point <= r_last;
                        r_res.retry_index <= last_inc;
                        r_state <= S_TIMER;
                    end else begin
                        if (put_write) r_last <= g[IDX_W-1:0];
                        r_state <= S_COMMIT;
                    end
                end
                S_COMMIT: begin
                    r_res.success     <= 1'b1;
                    r_res.match_point <= r_new;
                    if (r_in.entry_last && r_in.leader_commit_index > r_commit) begin
                        r_commit <= new_commit;
                        if (new_commit < r_base ||
                            (new_commit - r_base) >= {23'd0, r_thr}) begin
                            r_rd_idx <= new_commit;
                            r_ret    <= S_COMP;
                            r_state  <= S_RD;
                        end else begin
                            r_state <= S_TIMER;
                        end
                    end else begin
                        r_state <= S_TIMER;
                    end
                end
                S_COMP: begin
                    // advance the log base to the commit index
                    r_base_term <= rd_term;
                    r_base      <= r_rd_idx;
                    r_state     <= S_TIMER;
                end
                S_SNAP: begin
                    if (!(r_in.ref_index < r_last && rd_term == r_in.ref_term))
                        r_last <= r_in.ref_index;
                    r_base      <= r_in.ref_index;
                    r_base_term <= r_in.ref_term;
                    if (r_commit < r_in.ref_index) r_commit <= r_in.ref_index;
                    r_res.success     <= 1'b1;
                    r_res.match_point <= r_in.ref_index;
                    r_state <= S_TIMER;
                end
                S_TIMER: begin
                    // term and commit index are final from here on
                    r_res.reply_term   <= r_term;
                    r_res.commit_point <= r_commit;
                    r_state <= r_tpend ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_timeout <= {1'b0, eb} + {1'b0, div_rsp.rem};
                        r_tpend   <= 1'b0;
                        r_state   <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is at work");

    a_div_only_when_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("remainder finished outside its wait state");

    a_timer_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !r_tpend)
        else $error("result issued with a pending timeout draw");

endmodule
`default_nettype wire

>>> rtl/rfre_mod16.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rfre_mod16
// Restoring remainder unit, one dividend bit per cycle, for the timeout draw.
// ----------------------------------------------------------------------------
module rfre_mod16 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rfre_pkg::TMR_W-1:0] i_dividend,
    input  wire logic [rfre_pkg::CFG_W-1:0] i_divisor,
    output      rfre_pkg::t_div_rsp        o_rsp
);
    import rfre_pkg::*;

    logic              r_busy;
    logic [3:0]        r_cnt;
    logic [TMR_W-1:0]  r_dvd;
    logic [CFG_W-1:0]  r_rem;
    logic [CFG_W-1:0]  r_dsr;
    logic              r_done;
    logic [CFG_W:0]    shifted;
    logic [CFG_W:0]    diff;

    always_comb begin
        shifted = {r_rem, r_dvd[TMR_W-1]};
        diff    = shifted - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == 4'hF);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                // keep the partial remainder below the divisor
                if (shifted >= {1'b0, r_dsr}) r_rem <= diff[CFG_W-1:0];
                else                          r_rem <= shifted[CFG_W-1:0];
                r_dvd <= {r_dvd[TMR_W-2:0], 1'b0};
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'hF) r_busy <= 1'b0;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule
`default_nettype wire

>>> bench/rfre_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfre_checker
// Watches both channels and the register port of the Raft follower engine,
// predicts each result item from its own copy of terms, log ring, indices and
// timers, and compares every field of each result with the oldest prediction.
// ----------------------------------------------------------------------------
module rfre_checker
    import rfre_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire t_in                i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire t_out               i_out_item,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output      int                 o_errors,
    output      int                 o_pending,
    output      logic [IDX_W-1:0]   o_term,
    output      logic [IDX_W-1:0]   o_base,
    output      logic [IDX_W-1:0]   o_last,
    output      logic [IDX_W-1:0]   o_commit,
    output      logic [TERM_W-1:0]  o_last_term
);

    localparam int QDEPTH = 16;

    logic [CFG_W-1:0]  election_q, heartbeat_q;
    logic [7:0]        compact_q;
    logic [TERM_W-1:0] term_q, base_term_q;
    logic [ID_BITS:0]  vote_q, leader_q;
    logic [TERM_W-1:0] ring [256];
    logic [IDX_W-1:0]  base_q, last_q, commit_q;
    logic [TMR_W-1:0]  contact_q, timeout_q, beat_q, lfsr_q;
    t_out              replies_q [QDEPTH];
    int                head_q = 0;
    int                tail_q = 0;
    int                errors;

    assign o_errors    = errors;
    assign o_pending   = tail_q - head_q;
    assign o_term      = term_q;
    assign o_base      = base_q;
    assign o_last      = last_q;
    assign o_commit    = commit_q;
    assign o_last_term = (last_q == base_q) ? base_term_q : ring[last_q[7:0]];

    function automatic logic [TERM_W-1:0] term_of(input logic [IDX_W-1:0] idx);
        if (idx == base_q) return base_term_q;
        return ring[idx[7:0]];
    endfunction

    function automatic logic [IDX_W-1:0] sat_inc(input logic [IDX_W-1:0] v);
        return (v == IDX_MAX) ? v : v + 1'b1;
    endfunction

    // advance the LFSR and draw a fresh election timeout
    function automatic void restart_timer();
        logic [TMR_W-1:0] b;
        logic             fb;
        b = (election_q == '0) ? 16'd1 : {1'b0, election_q};
        fb = lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5];
        lfsr_q = {fb, lfsr_q[15:1]};
        contact_q = '0;
        timeout_q = b + lfsr_q % b;
    endfunction

    function automatic bit log_fresh(input logic [IDX_W-1:0] ri, input logic [TERM_W-1:0] rt);
        logic [TERM_W-1:0] lt;
        lt = term_of(last_q);
        if (rt != lt) return rt > lt;
        return ri >= last_q;
    endfunction

    function automatic bit heed_leader(input t_in it);
        bit bf;
        bf = 0;
        if (it.msg_term > term_q) begin
            term_q = it.msg_term;
            vote_q = NO_ID;
            bf = 1;
        end else if (it.local_role == ROLE_CAND || it.local_role == ROLE_LEADER) begin
            bf = 1;
        end
        if (bf) beat_q = '0;
        leader_q = {1'b0, it.sender_id};
        restart_timer();
        return bf;
    endfunction

    function automatic t_out follower_reply(input t_in it);
        t_out              r;
        longint unsigned   g;
        logic [IDX_W-1:0]  newest, ci;
        logic [TERM_W-1:0] ct;
        bit                keep;
        r = '0;
        r.retry_term = -32'sd1;
        r.status = ST_OK;
        case (it.action)
            ACT_TICK: begin
                if (contact_q != TMR_MAX) contact_q++;
                if (it.local_role == ROLE_LEADER) begin
                    if (beat_q != TMR_MAX) beat_q++;
                    if (beat_q >= {1'b0, heartbeat_q}) begin
                        r.heartbeat_due = 1'b1;
                        beat_q = '0;
                    end
                end else if (contact_q >= timeout_q) begin
                    r.election_due = 1'b1;
                    restart_timer();
                end
            end
            ACT_VOTE: begin
                if (it.msg_term < term_q) begin
                    r.status = ST_STALE;
                end else begin
                    if (it.msg_term > term_q) begin
                        term_q = it.msg_term;
                        vote_q = NO_ID;
                        leader_q = NO_ID;
                        beat_q = '0;
                        restart_timer();
                        r.became_follower = 1'b1;
                    end
                    if ((vote_q == NO_ID || vote_q == {1'b0, it.sender_id}) &&
                        log_fresh(it.ref_index, it.ref_term)) begin
                        vote_q = {1'b0, it.sender_id};
                        restart_timer();
                        r.success = 1'b1;
                    end
                end
            end
            ACT_PRE: begin
                if (it.msg_term <= term_q) begin
                    r.status = ST_STALE;
                end else if (!(it.local_role == ROLE_LEADER ||
                        (leader_q != NO_ID && int'(contact_q) < 2 * int'(heartbeat_q))) &&
                        log_fresh(it.ref_index, it.ref_term)) begin
                    r.success = 1'b1;
                end
            end
            ACT_APP: begin
                if (it.msg_term < term_q) begin
                    r.status = ST_STALE;
                    r.match_point = last_q;
                    r.retry_index = sat_inc(last_q);
                end else begin
                    r.became_follower = heed_leader(it);
                    if (it.ref_index < base_q) begin
                        r.status = ST_COMPACT;
                        r.match_point = (base_q != '0) ? base_q - 1'b1 : '0;
                        r.retry_index = base_q;
                        r.retry_term = {1'b0, base_term_q};
                    end else if (it.ref_index > last_q) begin
                        r.status = ST_MISSING;
                        r.match_point = last_q;
                        r.retry_index = sat_inc(last_q);
                    end else if (term_of(it.ref_index) != it.ref_term) begin
                        // walk back over the run of entries with the same term
                        ct = term_of(it.ref_index);
                        ci = it.ref_index;
                        while (ci > base_q && term_of(ci - 1'b1) == ct) ci--;
                        r.status = ST_MISMATCH;
                        r.retry_term = {1'b0, ct};
                        r.retry_index = ci;
                        r.match_point = (ci != '0) ? ci - 1'b1 : '0;
                    end else begin
                        g = 64'(it.ref_index) + 64'd1 + 64'(it.entry_pos);
                        newest = it.ref_index;
                        if (it.has_entry) begin
                            if (g > 64'(IDX_MAX)) r.status = ST_FULL;
                            if (r.status == ST_OK && g <= 64'(last_q) &&
                                term_of(g[IDX_W-1:0]) != it.entry_term)
                                last_q = g[IDX_W-1:0] - 1'b1;
                            if (r.status == ST_OK && g > 64'(last_q) + 64'd1) begin
                                r.status = ST_MISSING;
                            end else if (r.status == ST_OK && g == 64'(last_q) + 64'd1) begin
                                if (g - 64'(base_q) > 64'd256) begin
                                    r.status = ST_FULL;
                                end else begin
                                    ring[g[7:0]] = it.entry_term;
                                    last_q = g[IDX_W-1:0];
                                end
                            end
                            newest = g[IDX_W-1:0];
                        end
                        if (r.status == ST_MISSING || r.status == ST_FULL) begin
                            r.match_point = last_q;
                            r.retry_index = sat_inc(last_q);
                        end else begin
                            r.success = 1'b1;
                            r.match_point = newest;
                            if (it.entry_last && it.leader_commit_index > commit_q) begin
                                commit_q = (it.leader_commit_index < newest) ?
                                           it.leader_commit_index : newest;
                                if (commit_q - base_q >= {23'b0, compact_q}) begin
                                    base_term_q = term_of(commit_q);
                                    base_q = commit_q;
                                end
                            end
                        end
                    end
                end
            end
            ACT_SNAP: begin
                if (it.msg_term < term_q) begin
                    r.status = ST_STALE;
                    r.match_point = base_q;
                end else begin
                    r.became_follower = heed_leader(it);
                    if (it.ref_index > base_q) begin
                        keep = it.ref_index < last_q && term_of(it.ref_index) == it.ref_term;
                        if (!keep) last_q = it.ref_index;
                        base_q = it.ref_index;
                        base_term_q = it.ref_term;
                        if (commit_q < it.ref_index) commit_q = it.ref_index;
                    end
                    r.success = 1'b1;
                    r.match_point = base_q;
                end
            end
            default: ;
        endcase
        r.reply_term = term_q;
        r.commit_point = commit_q;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s is %h, predicted %h", $realtime, field, got, want);
        errors++;
    endtask

    task automatic compare_reply(input t_out got, input t_out want);
        if (got.reply_term !== want.reply_term)
            report("reply_term", 32'(got.reply_term), 32'(want.reply_term));
        if (got.success !== want.success)
            report("success", 32'(got.success), 32'(want.success));
        if (got.match_point !== want.match_point)
            report("match_point", 32'(got.match_point), 32'(want.match_point));
        if (got.retry_index !== want.retry_index)
            report("retry_index", 32'(got.retry_index), 32'(want.retry_index));
        if (got.retry_term !== want.retry_term)
            report("retry_term", got.retry_term, want.retry_term);
        if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
        if (got.commit_point !== want.commit_point)
            report("commit_point", 32'(got.commit_point), 32'(want.commit_point));
        if (got.election_due !== want.election_due)
            report("election_due", 32'(got.election_due), 32'(want.election_due));
        if (got.heartbeat_due !== want.heartbeat_due)
            report("heartbeat_due", 32'(got.heartbeat_due), 32'(want.heartbeat_due));
        if (got.became_follower !== want.became_follower)
            report("became_follower", 32'(got.became_follower), 32'(want.became_follower));
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            election_q = ELECTION_RST;
            heartbeat_q = HEARTBEAT_RST;
            compact_q = COMPACT_RST;
            term_q = '0;
            vote_q = NO_ID;
            leader_q = NO_ID;
            for (int k = 0; k < 256; k++) ring[k] = '0;
            base_q = '0;
            base_term_q = '0;
            last_q = '0;
            commit_q = '0;
            contact_q = '0;
            beat_q = '0;
            lfsr_q = LFSR_SEED;
            timeout_q = {1'b0, ELECTION_RST};
            head_q = 0;
            tail_q = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ELECTION:  election_q = i_cfg_data;
                    CFG_HEARTBEAT: heartbeat_q = i_cfg_data;
                    CFG_COMPACT:   compact_q = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                replies_q[tail_q % QDEPTH] = follower_reply(i_in_item);
                tail_q++;
            end
            if (i_out_valid && i_out_ready) begin
                if (tail_q == head_q) begin
                    $display("%0t: result item with no prediction waiting", $realtime);
                    errors++;
                end else begin
                    compare_reply(i_out_item, replies_q[head_q % QDEPTH]);
                    head_q++;
                end
            end
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the Raft follower engine: directed corner items,
// then phases of random message traffic under several register settings,
// with bursty input and a stalling receiver. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import rfre_pkg::*;

    localparam logic [IDX_W-1:0] TOP = IDX_MAX;
    localparam int               CYCLE_LIMIT = 3000000;
    localparam int               SETTLE = 40;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    t_in              in_item = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_item;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_idx = CFG_ELECTION;
    logic [CFG_W-1:0] cfg_data = '0;

    int               errors, pending;
    logic [IDX_W-1:0] cur_term, cur_base, cur_last, cur_commit;
    logic [TERM_W-1:0] cur_last_term;

    int  cycles = 0;
    int  burst_left = 0;
    int  sent = 0;
    bit  hold_commit = 0;   // keep the commit index still so the ring fills up
    logic [6:0] stall_phase = '0;

    raft_follower_rpc_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    rfre_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending),
        .o_term(cur_term), .o_base(cur_base), .o_last(cur_last),
        .o_commit(cur_commit), .o_last_term(cur_last_term)
    );

    initial forever #6 clk = ~clk;

    // Bail out if the block hangs.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: long stretches of full rate alternate with stretches of
    // random stalls.
    always @(posedge clk) begin
        stall_phase <= stall_phase + 1'b1;
        if (stall_phase[6]) out_ready <= ($urandom_range(0, 2) != 0);
        else out_ready <= 1'b1;
    end

    function automatic logic [IDX_W-1:0] up(input logic [IDX_W-1:0] v, input int d);
        return (64'(v) + 64'(d) > 64'(TOP)) ? TOP : v + IDX_W'(d);
    endfunction

    function automatic logic [IDX_W-1:0] down(input logic [IDX_W-1:0] v, input int d);
        return (v < IDX_W'(d)) ? '0 : v - IDX_W'(d);
    endfunction

    function automatic t_in msg(input logic [2:0] act, input logic [1:0] role,
                                input logic [TERM_W-1:0] mt, input logic [IDX_W-1:0] ri,
                                input logic [TERM_W-1:0] rt);
        t_in it;
        it = '0;
        it.action = act;
        it.local_role = role;
        it.msg_term = mt;
        it.sender_id = 8'($urandom_range(1, 3));
        it.ref_index = ri;
        it.ref_term = rt;
        return it;
    endfunction

    // Present one item and hold it until taken, then drop valid so the next
    // item is built from the settled prediction.
    task automatic send(input t_in it);
        in_item <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        in_valid <= 1'b0;
        sent++;
        @(posedge clk);
        if (--burst_left <= 0) begin
            repeat ($urandom_range(0, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
    endtask

    // Write a register once the block has drained.
    task automatic write_reg(input logic [1:0] idx, input int val);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_append(input logic [TERM_W-1:0] mt, input logic [1:0] role,
                               input logic [IDX_W-1:0] ri, input logic [TERM_W-1:0] rt,
                               input int count, input bit carry,
                               input logic [IDX_W-1:0] lc);
        t_in it;
        int  pos;
        pos = 0;
        for (int k = 0; k < count; k++) begin
            it = msg(ACT_APP, role, mt, ri, rt);
            it.has_entry = carry;
            it.entry_pos = 8'(pos);
            it.entry_term = mt;
            it.entry_last = (k == count - 1);
            it.leader_commit_index = lc;
            send(it);
            // occasionally skip a position to open a gap
            pos += ($urandom_range(0, 19) == 0) ? 2 : 1;
        end
    endtask

    task automatic random_traffic(input int n);
        t_in               it;
        int                stop, kind, sel, k;
        logic [1:0]        role;
        logic [TERM_W-1:0] mt, rt;
        logic [IDX_W-1:0]  ri;
        stop = sent + n;
        while (sent < stop) begin
            kind = $urandom_range(0, 99);
            role = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3)) : 2'd0;
            case ($urandom_range(0, 19))
                0:       mt = down(cur_term, 1);
                1, 2:    mt = up(cur_term, 1);
                default: mt = cur_term;
            endcase
            if (kind < 12) begin
                it = msg(ACT_TICK, ($urandom_range(0, 2) == 0) ? ROLE_LEADER
                         : 2'($urandom_range(0, 3)), '0, '0, '0);
                send(it);
            end else if (kind < 27) begin
                ri = ($urandom_range(0, 2) == 0) ? up(down(cur_last, 1), $urandom_range(0, 2))
                     : cur_last;
                rt = ($urandom_range(0, 2) == 0) ? up(down(cur_last_term, 1), $urandom_range(0, 2))
                     : cur_last_term;
                it = msg((kind < 20) ? ACT_VOTE : ACT_PRE, role,
                         (kind < 20) ? mt : up(cur_term, $urandom_range(0, 2)), ri, rt);
                if ($urandom_range(0, 7) == 0) it.sender_id = 8'($urandom);
                send(it);
            end else if (kind < 80) begin
                sel = $urandom_range(0, 9);
                ri = cur_last;
                rt = cur_last_term;
                if (sel == 7 && cur_last > cur_base) begin
                    ri = down(cur_last, $urandom_range(1, (cur_last - cur_base > 8) ? 8
                                                          : int'(cur_last - cur_base)));
                    rt = $urandom_range(0, int'(cur_term[7:0]) + 1);
                end else if (sel == 8) begin
                    ri = up(cur_last, $urandom_range(1, 3));
                end else if (sel == 9) begin
                    ri = down(cur_base, 1);
                    rt = '0;
                end
                k = $urandom_range(1, 6);
                send_append(mt, role, ri, rt, k, $urandom_range(0, 9) != 0,
                            hold_commit ? cur_commit : up(cur_commit, $urandom_range(0, k + 3)));
            end else if (kind < 90) begin
                ri = up(cur_base, $urandom_range(0, hold_commit ? 2
                        : ((cur_last - cur_base > 20) ? 20 : int'(cur_last - cur_base)) + 2));
                rt = ($urandom_range(0, 1) == 0) ? cur_term : down(cur_term, 1);
                send(msg(ACT_SNAP, role, mt, ri, rt));
            end else begin
                // noise: every field random, mostly stale so the log survives
                it = t_in'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
                it.action = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 3) != 0) it.msg_term = '0;
                send(it);
            end
        end
    endtask

    initial begin
        t_in it;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners under the reset settings.
        send(msg(ACT_TICK, 2'd0, '0, '0, '0));
        send(msg(ACT_TICK, ROLE_LEADER, '0, '0, '0));
        send(msg(ACT_PRE, 2'd0, 31'd1, '0, '0));                 // pre-vote granted
        send(msg(ACT_PRE, 2'd0, '0, '0, '0));                    // pre-vote, term not ahead
        it = msg(ACT_VOTE, ROLE_CAND, 31'd1, '0, '0);
        it.sender_id = 8'd3;
        send(it);                                                // new term, vote granted
        it.sender_id = 8'd4;
        send(it);                                                // vote already given
        send(msg(ACT_VOTE, 2'd0, '0, '0, '0));                   // stale vote
        send_append(31'd1, ROLE_CAND, '0, '0, 3, 1'b1, 31'd2);   // same-term step-down
        it = msg(ACT_APP, 2'd0, 31'd1, 31'd1, 31'd1);
        it.has_entry = 1'b1;
        it.entry_pos = 8'd5;
        it.entry_term = 31'd1;
        send(it);                                                // entry gap
        send(msg(ACT_APP, 2'd0, 31'd1, 31'd2, 31'd7));           // term mismatch
        send(msg(ACT_APP, 2'd0, 31'd1, 31'd9, 31'd1));           // missing previous entry
        send(msg(ACT_APP, 2'd0, '0, '0, '0));                    // stale append
        send(msg(ACT_SNAP, ROLE_LEADER, 31'd1, 31'd2, 31'd1));   // snapshot keeps the tail
        send(msg(ACT_APP, 2'd0, 31'd1, 31'd1, 31'd1));           // below the base
        send(msg(ACT_SNAP, 2'd0, '0, '0, '0));                   // stale snapshot
        send(msg(ACT_TICK, 2'd3, '0, '0, '0));                   // role three acts as follower
        for (int a = 5; a < 8; a++) send(msg(3'(a), 2'd0, 31'd1, '0, '0));

        write_reg(CFG_ELECTION, $urandom_range(3, 20));
        write_reg(CFG_HEARTBEAT, $urandom_range(1, 5));
        write_reg(CFG_COMPACT, $urandom_range(1, 8));
        random_traffic(350);

        write_reg(CFG_ELECTION, 1);
        write_reg(CFG_HEARTBEAT, 1);
        write_reg(CFG_COMPACT, 1);
        random_traffic(250);

        // Zero election base and a frozen commit index: fill the ring.
        write_reg(CFG_ELECTION, 0);
        write_reg(CFG_HEARTBEAT, 32767);
        write_reg(CFG_COMPACT, 255);
        hold_commit = 1;
        random_traffic(350);
        hold_commit = 0;

        write_reg(CFG_ELECTION, 32767);
        write_reg(CFG_HEARTBEAT, $urandom_range(1, 32767));
        write_reg(CFG_COMPACT, $urandom_range(1, 255));
        random_traffic(150);

        // Highest term and indices at the top of the range.
        send(msg(ACT_SNAP, 2'd0, TOP, TOP - 1'b1, TOP));
        send_append(TOP, 2'd0, TOP - 1'b1, TOP, 1, 1'b1, TOP);
        send_append(TOP, 2'd0, TOP, TOP, 1, 1'b1, TOP);          // index passes 31 bits
        send(msg(ACT_VOTE, 2'd0, TOP, TOP, TOP));
        send(msg(ACT_PRE, 2'd0, TOP, TOP, TOP));

        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/rfre_pkg.sv
rtl/rfre_mod16.sv
rtl/raft_follower_rpc_engine.sv
bench/rfre_checker.sv
bench/tb.sv
